// ===== design/modbus_rtu_write_frame_builder_macros.svh =====
// Assertion shorthands shared by the frame builder.
`ifndef MODBUS_RTU_WRITE_FRAME_BUILDER_MACROS_SVH
`define MODBUS_RTU_WRITE_FRAME_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBRTU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame builder check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBRTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame builder check failed");

`endif

// ===== design/mbrtu_pkg.sv =====
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam logic [15:0] CRC_START  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_WRITE = 8'h06;

  // Control from the byte sequencer to the CRC unit.
  typedef struct packed {
    logic restart;  // start over from CRC_START
    logic fold;     // fold the presented byte in
  } crc_ctl_t;

  // One byte through the reflected CRC-16, eight shift steps.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/mbrtu_ifs.sv =====
`timescale 1ns / 1ps

interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_payload;
  modport source(output valid, payload_byte, last_payload, input ready);
  modport sink(input valid, payload_byte, last_payload, output ready);
endinterface

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_frame;
  modport source(output valid, out_byte, last_of_run, end_of_frame, input ready);
  modport sink(input valid, out_byte, last_of_run, end_of_frame, output ready);
endinterface

interface mbrtu_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_address;
  modport source(output valid, device_address, input ready);
  modport sink(input valid, device_address, output ready);
endinterface

// ===== design/modbus_rtu_write_frame_builder.sv =====
`timescale 1ns / 1ps
// The first byte of an item passes the holding register and then the output register.
// Throughput: one output byte per cycle while the receiver is ready, set by the single output
// register. An item yields one byte (middle), three (first or last) or five (one-item frame).
// A new item is taken in the cycle its predecessor emits its final byte.
// Reset (synchronous, active high): address 1, CRC 0xFFFF, waiting for the start of a frame.

module modbus_rtu_write_frame_builder (
  input logic         clk,
  input logic         rst,
  mbrtu_in_if.sink    payload,
  mbrtu_out_if.source frame,
  mbrtu_cfg_if.sink   cfg
);
  import mbrtu_pkg::*;

  `include "modbus_rtu_write_frame_builder_macros.svh"

  // Which byte of the frame the held item emits next. Idling in PH_PAY means a
  // frame is open (address and function already sent); idling in PH_ADDR means
  // the next item starts a new frame.
  localparam logic [2:0] PH_ADDR = 3'd0;
  localparam logic [2:0] PH_FUNC = 3'd1;
  localparam logic [2:0] PH_PAY  = 3'd2;
  localparam logic [2:0] PH_CRCL = 3'd3;
  localparam logic [2:0] PH_CRCH = 3'd4;

  logic [7:0]  device_address;
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;
  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_eof;
  logic        out_load;
  logic        emit;
  logic        item_done;
  logic        accept;
  logic [7:0]  byte_sel;
  logic [15:0] crc;
  crc_ctl_t    crc_ctl;

  // The configuration register is always writable. Writes must arrive only while the block
  // is idle, which the block does not enforce; the address is read only when a frame starts,
  // so a write between two items of an open frame takes effect with the next frame.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
    end else if (cfg.valid) begin
      device_address <= cfg.device_address;
    end
  end

  // The output register takes a new byte when it is empty or being drained.
  assign out_load  = !out_valid || frame.ready;
  assign emit      = hold_valid && out_load;
  // The held item is finished on its final byte: the payload byte of a middle
  // item, or the CRC high byte of a closing item.
  assign item_done = emit && ((phase == PH_PAY && !hold_last) || phase == PH_CRCH);

  // The holding register refills in the same cycle it empties, so items stream
  // back to back when each yields a single byte.
  assign payload.ready = !hold_valid || item_done;
  assign accept        = payload.valid && payload.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (item_done) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= payload.payload_byte;
      hold_last <= payload.last_payload;
    end
  end

  always_comb begin
    case (phase)
      PH_ADDR: begin
        phase_next = PH_FUNC;
        byte_sel   = device_address;
      end
      PH_FUNC: begin
        phase_next = PH_PAY;
        byte_sel   = FUNC_WRITE;
      end
      PH_PAY: begin
        phase_next = hold_last ? PH_CRCL : PH_PAY;
        byte_sel   = hold_byte;
      end
      PH_CRCL: begin
        phase_next = PH_CRCH;
        byte_sel   = crc[7:0];
      end
      PH_CRCH: begin
        phase_next = PH_ADDR;
        byte_sel   = crc[15:8];
      end
      default: begin
        phase_next = PH_ADDR;
        byte_sel   = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ADDR;
    end else if (emit) begin
      phase <= phase_next;
    end
  end

  // Address, function and payload bytes are folded as they leave; the CRC bytes
  // are not. The address fold starts from the initial value, and the CRC high
  // byte resets the register for the next frame.
  assign crc_ctl.restart = emit && (phase == PH_ADDR || phase == PH_CRCH);
  assign crc_ctl.fold    = emit && (phase == PH_ADDR || phase == PH_FUNC || phase == PH_PAY);

  mbrtu_crc16 u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (byte_sel),
    .crc  (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_sel;
      out_last <= (phase == PH_PAY && !hold_last) || phase == PH_CRCH;
      out_eof  <= phase == PH_CRCH;
    end
  end

  assign frame.valid        = out_valid;
  assign frame.out_byte     = out_byte;
  assign frame.last_of_run  = out_last;
  assign frame.end_of_frame = out_eof;

  // The closing CRC byte always ends the run of its item.
  `MBRTU_ASSERT_SAME(a_eof_ends_run, clk, rst, frame.valid && frame.end_of_frame, frame.last_of_run)
  // A frame always restarts at the address once the CRC high byte has gone out.
  `MBRTU_ASSERT_NEXT(a_restart_after_crc, clk, rst, emit && phase == PH_CRCH, phase == PH_ADDR)
  // The byte after the address is always the write function code.
  `MBRTU_ASSERT_NEXT(a_func_code, clk, rst, emit && phase == PH_FUNC, frame.out_byte == FUNC_WRITE)
  // An accepted item is always held for the sequencer.
  `MBRTU_ASSERT_NEXT(a_accept_holds, clk, rst, accept, hold_valid)

endmodule

// ===== design/mbrtu_crc16.sv =====
`timescale 1ns / 1ps

module mbrtu_crc16 (
  input  logic                clk,
  input  logic                rst,
  input  mbrtu_pkg::crc_ctl_t ctl,
  input  logic [7:0]          data,
  output logic [15:0]         crc
);
  import mbrtu_pkg::*;

  logic [15:0] fold_base;

  assign fold_base = ctl.restart ? CRC_START : crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_START;
    end else if (ctl.fold) begin
      crc <= crc_fold(fold_base, data);
    end else if (ctl.restart) begin
      crc <= CRC_START;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the Modbus RTU write-single-register frame builder.
//
// Payload bytes go in on the payload channel. For each frame, the block sends out
// the device address, the write function code, the payload bytes and then the
// CRC-16 bytes. A model inside this bench builds the same byte stream. Every byte
// that leaves the frame channel is compared with the oldest byte the model still
// owes. The stimulus starts with a short table of hand-picked items. A long run of
// random frames follows, spread over several address settings.
module tb;
  import mbrtu_pkg::CRC_START;
  import mbrtu_pkg::CRC_POLY;
  import mbrtu_pkg::FUNC_WRITE;

  // One byte of the outgoing frame, with its two markers.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_frame;
  } frame_byte_t;

  // One row of the hand-written stimulus table. When set_addr is high, the bench
  // rewrites the address register before this item, once the block has gone quiet.
  // When typed_en is high, the row's expected bytes are written out in typed. They
  // are in wire order and right-aligned, so byte i of an n-byte run is
  // typed[n-1-i].
  typedef struct packed {
    bit              set_addr;
    logic [7:0]      addr;
    logic [7:0]      pb;
    bit              lastp;
    bit              typed_en;
    logic [2:0][7:0] typed;
  } stim_row_t;

  // Receiver ready patterns. The receiver steps through them on its own cycle count.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_EVERY_THIRD,
    RX_SPARSE
  } rx_pattern_e;

  localparam int DIR_ROWS_N = 21;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 56;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int ERR_PRINT_CAP = 60;

  localparam stim_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
    // After reset the address is 1. An all-zero first byte opens the frame.
    '{1'b0, 8'h00, 8'h00, 1'b0, 1'b1, {8'h01, 8'h06, 8'h00}},
    '{1'b0, 8'h00, 8'hFF, 1'b0, 1'b1, 24'h0000FF},
    '{1'b0, 8'h00, 8'h80, 1'b1, 1'b0, 24'h0},
    // This row sets address zero and sends a frame of one byte, so five bytes come out.
    '{1'b1, 8'h00, 8'h01, 1'b1, 1'b0, 24'h0},
    '{1'b1, 8'hFF, 8'h55, 1'b0, 1'b1, {8'hFF, 8'h06, 8'h55}},
    '{1'b0, 8'h00, 8'hAA, 1'b0, 1'b1, 24'h0000AA},
    // The first of these rows writes the address while a frame is open. The open frame keeps
    // address FF, and its CRC still covers FF.
    '{1'b1, 8'h7C, 8'h00, 1'b0, 1'b1, 24'h000000},
    '{1'b0, 8'h00, 8'hFF, 1'b1, 1'b0, 24'h0},
    '{1'b0, 8'h00, 8'h12, 1'b0, 1'b1, {8'h7C, 8'h06, 8'h12}},
    // A longer frame, with a walking one in the payload.
    '{1'b0, 8'h00, 8'h01, 1'b0, 1'b1, 24'h000001},
    '{1'b0, 8'h00, 8'h02, 1'b0, 1'b1, 24'h000002},
    '{1'b0, 8'h00, 8'h04, 1'b0, 1'b1, 24'h000004},
    '{1'b0, 8'h00, 8'h08, 1'b0, 1'b1, 24'h000008},
    '{1'b0, 8'h00, 8'h10, 1'b0, 1'b1, 24'h000010},
    '{1'b0, 8'h00, 8'h20, 1'b0, 1'b1, 24'h000020},
    '{1'b0, 8'h00, 8'h40, 1'b0, 1'b1, 24'h000040},
    '{1'b0, 8'h00, 8'h80, 1'b1, 1'b0, 24'h0},
    '{1'b0, 8'h00, 8'hFF, 1'b1, 1'b0, 24'h0},
    '{1'b1, 8'h80, 8'h00, 1'b1, 1'b0, 24'h0},
    '{1'b1, 8'h01, 8'h3C, 1'b0, 1'b1, {8'h01, 8'h06, 8'h3C}},
    '{1'b0, 8'h00, 8'hC3, 1'b1, 1'b0, 24'h0}
  };

  logic clk;
  logic rst;

  mbrtu_in_if  pay_if ();
  mbrtu_out_if frm_if ();
  mbrtu_cfg_if cfg_if ();

  modbus_rtu_write_frame_builder dut (
    .clk     (clk),
    .rst     (rst),
    .payload (pay_if.sink),
    .frame   (frm_if.source),
    .cfg     (cfg_if.sink)
  );

  // This is the model's own copy of the block's state and its register.
  logic [7:0]  station_addr;
  logic [15:0] crc_acc;
  bit          frame_open;

  // The model puts each item's bytes here before they go into the queue of bytes still owed.
  frame_byte_t staged [0:4];
  frame_byte_t frame_due [$];

  int byte_errors;
  int burst_left;
  bit sender_no_gaps;
  int hold_asks;
  int hold_done;
  int hold_left;
  int unsigned rx_cycle;

  initial begin
    clk = 1'b0;
    forever begin
      #2 clk = ~clk;
    end
  end

  // The Modbus CRC runs one data bit at a time, LSB first. The polynomial is
  // reflected, and no XOR is applied at the end.
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] acc,
                                                    input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Builds the bytes that one payload item sets off and places them in staged.
  // Returns how many bytes there are.
  function automatic int predict_frame_bytes(input logic [7:0] pb, input bit lastp);
    int n;
    n = 0;
    if (!frame_open) begin
      crc_acc = CRC_START;
      staged[n] = '{out_byte: station_addr, last_of_run: 1'b0, end_of_frame: 1'b0};
      crc_acc = crc16_modbus_byte(crc_acc, station_addr);
      n++;
      staged[n] = '{out_byte: FUNC_WRITE, last_of_run: 1'b0, end_of_frame: 1'b0};
      crc_acc = crc16_modbus_byte(crc_acc, FUNC_WRITE);
      n++;
      frame_open = 1'b1;
    end
    staged[n] = '{out_byte: pb, last_of_run: 1'b0, end_of_frame: 1'b0};
    crc_acc = crc16_modbus_byte(crc_acc, pb);
    n++;
    if (lastp) begin
      // The CRC goes out low byte first. Its own bytes are never folded back in.
      staged[n] = '{out_byte: crc_acc[7:0], last_of_run: 1'b0, end_of_frame: 1'b0};
      n++;
      staged[n] = '{out_byte: crc_acc[15:8], last_of_run: 1'b0, end_of_frame: 1'b1};
      n++;
      crc_acc = CRC_START;
      frame_open = 1'b0;
    end
    staged[n-1].last_of_run = 1'b1;
    return n;
  endfunction

  // Offers one payload item. Once the current burst has run out, it may first leave a random
  // gap and start a new burst. It returns in the time step of the handshake, and by then
  // the bytes this item is owed are already in the queue.
  task automatic send_item(input logic [7:0] pb, input bit lastp,
                           input bit typed_en, input logic [2:0][7:0] typed);
    int n;
    if (!sender_no_gaps && burst_left <= 0) begin
      pay_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(40, 15) : $urandom_range(8, 1);
    end
    pay_if.valid        <= 1'b1;
    pay_if.payload_byte <= pb;
    pay_if.last_payload <= lastp;
    do @(posedge clk); while (!pay_if.ready);
    burst_left--;
    n = predict_frame_bytes(pb, lastp);
    for (int i = 0; i < n; i++) begin
      if (typed_en) begin
        // A typed row replaces the byte values with the ones written in the table.
        // The markers still come from the model.
        staged[i].out_byte = typed[n-1-i];
      end
      frame_due.push_back(staged[i]);
    end
  endtask

  // Stops sending and waits until every owed byte has come out. It then waits on
  // for the block's output register.
  task automatic quiesce();
    pay_if.valid <= 1'b0;
    burst_left = 0;
    while (frame_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the address register. The model takes the new value only once the
  // handshake is done. Like the block, it uses the value only when the next frame
  // opens.
  task automatic write_address(input logic [7:0] a);
    cfg_if.valid          <= 1'b1;
    cfg_if.device_address <= a;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    station_addr = a;
  endtask

  // The receiver's ready. A hold-off request drops ready for a long stretch, so
  // that the block backs up into its input. Apart from that, the pattern follows
  // bits 9:8 of the receiver's cycle count: always ready, mostly ready, ready one
  // cycle in three, and seldom ready.
  initial begin
    frm_if.ready <= 1'b0;
    rx_cycle  = 0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        frm_if.ready <= 1'b0;
      end else if (hold_asks != hold_done) begin
        hold_done++;
        hold_left = HOLD_OFF_CYCLES;
        frm_if.ready <= 1'b0;
      end else begin
        case (rx_pattern_e'(rx_cycle[9:8]))
          RX_OPEN: begin
            frm_if.ready <= 1'b1;
          end
          RX_MOSTLY: begin
            frm_if.ready <= ($urandom_range(3) != 0);
          end
          RX_EVERY_THIRD: begin
            frm_if.ready <= (rx_cycle % 3 == 0);
          end
          default: begin
            frm_if.ready <= ($urandom_range(9) < 3);
          end
        endcase
      end
    end
  end

  // Each byte that leaves the frame channel is compared with the oldest byte still
  // owed. A byte that nobody owes is a failure too.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && frm_if.valid && frm_if.ready) begin
      if (frame_due.size() == 0) begin
        byte_errors++;
        if (byte_errors <= ERR_PRINT_CAP) begin
          $error("out_byte: no byte expected, got %02h", frm_if.out_byte);
        end
      end else begin
        want = frame_due.pop_front();
        if (frm_if.out_byte !== want.out_byte) begin
          byte_errors++;
          if (byte_errors <= ERR_PRINT_CAP) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, frm_if.out_byte);
          end
        end
        if (frm_if.last_of_run !== want.last_of_run) begin
          byte_errors++;
          if (byte_errors <= ERR_PRINT_CAP) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   frm_if.last_of_run);
          end
        end
        if (frm_if.end_of_frame !== want.end_of_frame) begin
          byte_errors++;
          if (byte_errors <= ERR_PRINT_CAP) begin
            $error("end_of_frame: expected %0b, got %0b", want.end_of_frame,
                   frm_if.end_of_frame);
          end
        end
      end
    end
  end

  // The main sequence: reset, then the directed table, then the random phases.
  initial begin
    int         frame_left;
    bit         lastp;
    logic [7:0] phase_addr;
    byte_errors    = 0;
    burst_left     = 0;
    sender_no_gaps = 1'b0;
    hold_asks      = 0;
    frame_left     = 0;
    rst                   <= 1'b1;
    pay_if.valid          <= 1'b0;
    pay_if.payload_byte   <= 8'h00;
    pay_if.last_payload   <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.device_address <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    station_addr = 8'h01;
    crc_acc      = CRC_START;
    frame_open   = 1'b0;

    for (int r = 0; r < DIR_ROWS_N; r++) begin
      if (DIR_ROWS[r].set_addr) begin
        quiesce();
        write_address(DIR_ROWS[r].addr);
      end
      send_item(DIR_ROWS[r].pb, DIR_ROWS[r].lastp, DIR_ROWS[r].typed_en, DIR_ROWS[r].typed);
    end

    // Random frames. Most frames are one to four bytes long, and a few run to
    // thirty. The address changes at every phase boundary. The boundary often falls
    // inside an open frame, so this also tests writes made mid-frame. The sender
    // stops until the block is empty before each write.
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiesce();
      case (p)
        0: phase_addr = 8'h00;
        1: phase_addr = 8'hFF;
        5: phase_addr = 8'h01;
        default: phase_addr = 8'($urandom_range(255));
      endcase
      write_address(phase_addr);
      // In phase 3 the sender never leaves a gap.
      sender_no_gaps = (p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (frame_left == 0) begin
          frame_left = ($urandom_range(7) == 0) ? $urandom_range(30, 12)
                                                : $urandom_range(4, 1);
        end
        lastp = (frame_left == 1);
        frame_left--;
        if ((p == 1 || p == 4) && k == 10) begin
          // The receiver holds off for a long stretch, and the sender keeps offering items.
          hold_asks++;
        end
        send_item(8'($urandom_range(255)), lastp, 1'b0, 24'h0);
      end
    end

    pay_if.valid <= 1'b0;
    while (frame_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (byte_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // This watchdog ends the run if it hangs. The limit is far beyond the slowest
  // correct run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
